// ----- hw/rtl/utccet_pkg.sv -----
package utccet_pkg;

    // Field widths of the timestamp items.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int WDAY_W   = 3;

    // Reset value of the earliest synchronized year.
    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2024;

    // Reciprocal constants for division by 100 and by 7, exact for values below 2^15.
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [14:0] RECIP_7         = 15'd18725;
    localparam int          RECIP_7_SHIFT   = 17;

    // Calendar constants.
    localparam logic [8:0]        YEAR_CYCLE   = 9'd400;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_OCT   = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   LEAP_FEB    = 5'd29;
    localparam logic [HOUR_W:0]    HOURS_DAY   = 6'd24;
    localparam logic signed [6:0]  LAST_WEEK   = 7'sd25;

    // One UTC timestamp item.
    typedef struct packed {
        logic                time_valid;
        logic [YEAR_W-1:0]   utc_year;
        logic [MONTH_W-1:0]  utc_month;
        logic [DAY_W-1:0]    utc_day;
        logic [HOUR_W-1:0]   utc_hour;
        logic [MINUTE_W-1:0] utc_minute;
        logic [SECOND_W-1:0] utc_second;
    } t_utc_time;

    // One local time result item.
    typedef struct packed {
        logic                synced;
        logic [YEAR_W-1:0]   local_year;
        logic [MONTH_W-1:0]  local_month;
        logic [DAY_W-1:0]    local_day;
        logic [HOUR_W-1:0]   local_hour;
        logic [MINUTE_W-1:0] local_minute;
        logic [SECOND_W-1:0] local_second;
        logic                summer_time;
        logic [WDAY_W-1:0]   utc_weekday;
    } t_local_time;

    // Month term (31 * m) / 12 of the weekday sum, with months before March
    // shifted to the end of the previous year.
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] month);
        logic [5:0] t;
        case (month)
            4'd0:    t = 6'd25;
            4'd1:    t = 6'd28;
            4'd2:    t = 6'd31;
            4'd3:    t = 6'd2;
            4'd4:    t = 6'd5;
            4'd5:    t = 6'd7;
            4'd6:    t = 6'd10;
            4'd7:    t = 6'd12;
            4'd8:    t = 6'd15;
            4'd9:    t = 6'd18;
            4'd10:   t = 6'd20;
            4'd11:   t = 6'd23;
            4'd12:   t = 6'd25;
            4'd13:   t = 6'd28;
            4'd14:   t = 6'd31;
            default: t = 6'd33;
        endcase
        return t;
    endfunction

    // Length of a month in a common year; unused codes count 31 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] d;
        case (month)
            4'd2:    d = 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ----- hw/rtl/utccet_in_if.sv -----
interface utccet_in_if;
    logic                 valid;
    logic                 ready;
    utccet_pkg::t_utc_time data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/utccet_out_if.sv -----
interface utccet_out_if;
    logic                   valid;
    logic                   ready;
    utccet_pkg::t_local_time data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/utccet_cfg_if.sv -----
interface utccet_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [utccet_pkg::YEAR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/utc_to_cet_local_time_dst_unit.sv -----
// Channel   Dir  Payload                     Accepted when
// i_in      in   utc_time (valid+date/time)  i_in.valid & i_in.ready
// o_out     out  local_time + weekday        o_out.valid & o_out.ready
// i_cfg     in   min_year (14 bit)           i_cfg.valid & i_cfg.ready
//
// Five register stages: multiply by 1/100, weekday sum, multiply by 1/7,
// weekday remainder, then summer time and date rollover into the output register.
// An item enters every cycle while the output is not stalled; the two reciprocal
// multiplies each take a stage of their own.
// Reset (synchronous, active low) empties the pipeline and sets min_year to 2024.
// A stall at the output holds each full stage; empty stages still fill behind it.
module utc_to_cet_local_time_dst_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    utccet_in_if.sink      i_in,
    utccet_out_if.source   o_out,
    utccet_cfg_if.sink     i_cfg
);

    localparam int YW = utccet_pkg::YEAR_W;
    localparam int MW = utccet_pkg::MONTH_W;
    localparam int DW = utccet_pkg::DAY_W;
    localparam int HW = utccet_pkg::HOUR_W;
    // The shifted year (year + 400) and the weekday sum need one bit more than a year.
    localparam int SW = YW + 1;

    // Fields that travel unchanged through the first stages.
    typedef struct packed {
        logic                                synced;
        logic [YW-1:0]                       year;
        logic [MW-1:0]                       month;
        logic [DW-1:0]                       day;
        logic [HW-1:0]                       hour;
        logic [utccet_pkg::MINUTE_W-1:0]     minute;
        logic [utccet_pkg::SECOND_W-1:0]     second;
    } t_carry;

    logic [YW-1:0] r_min_year;

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    t_carry r1_c, r2_c, r3_c, r4_c;
    logic [SW-1:0] r1_y;
    logic [5:0]    r1_tm;
    logic [27:0]   r1_py;
    logic [26:0]   r1_pyr;
    logic [SW-1:0] r2_sum, r3_sum;
    logic          r2_leap, r3_leap, r4_leap;
    logic [29:0]   r3_p7;
    logic [utccet_pkg::WDAY_W-1:0] r4_wd;
    utccet_pkg::t_local_time r5_out;

    // Configuration register; writes are taken at any time.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= utccet_pkg::MIN_YEAR_RESET;
        end else if (i_cfg.valid) begin
            r_min_year <= i_cfg.data;
        end
    end

    // Each stage takes a new item when it is empty or its item moves on.
    assign rdy5 = !r5_vld || o_out.ready;
    assign rdy4 = !r4_vld || rdy5;
    assign rdy3 = !r3_vld || rdy4;
    assign rdy2 = !r2_vld || rdy3;
    assign rdy1 = !r1_vld || rdy2;
    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_in.valid;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
            if (rdy5) r5_vld <= r4_vld;
        end
    end

    // Stage 1: shifted year for the weekday and both divisions by 100.
    logic          n1_early;
    logic [SW-1:0] n1_y;
    t_carry        n1_c;

    always_comb begin
        n1_early = (i_in.data.utc_month <= utccet_pkg::MONTH_FEB);
        n1_y = SW'(i_in.data.utc_year) + SW'(utccet_pkg::YEAR_CYCLE) - SW'(n1_early);
        n1_c.synced = i_in.data.time_valid && (i_in.data.utc_year >= r_min_year);
        n1_c.year   = i_in.data.utc_year;
        n1_c.month  = i_in.data.utc_month;
        n1_c.day    = i_in.data.utc_day;
        n1_c.hour   = i_in.data.utc_hour;
        n1_c.minute = i_in.data.utc_minute;
        n1_c.second = i_in.data.utc_second;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_c   <= n1_c;
            r1_y   <= n1_y;
            r1_tm  <= utccet_pkg::month_term(i_in.data.utc_month);
            r1_py  <= n1_y * utccet_pkg::RECIP_100;
            r1_pyr <= i_in.data.utc_year * utccet_pkg::RECIP_100;
        end
    end

    // Stage 2: weekday sum and leap year test.
    logic [7:0]    n2_qy, n2_qyr;
    logic [SW-1:0] n2_sum;
    logic [YW-1:0] n2_rem;
    logic          n2_leap;

    always_comb begin
        n2_qy  = r1_py[utccet_pkg::RECIP_100_SHIFT +: 8];
        n2_qyr = r1_pyr[utccet_pkg::RECIP_100_SHIFT +: 8];
        n2_sum = SW'(r1_c.day) + r1_y + (r1_y >> 2) + SW'(n2_qy >> 2)
                 + SW'(r1_tm) - SW'(n2_qy);
        n2_rem = r1_c.year - YW'(n2_qyr) * YW'(7'd100);
        n2_leap = (r1_c.year[1:0] == 2'd0) && ((n2_rem != '0) || (n2_qyr[1:0] == 2'd0));
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_c    <= r1_c;
            r2_sum  <= n2_sum;
            r2_leap <= n2_leap;
        end
    end

    // Stage 3: multiply the weekday sum by 1/7.
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_c    <= r2_c;
            r3_sum  <= r2_sum;
            r3_leap <= r2_leap;
            r3_p7   <= r2_sum * utccet_pkg::RECIP_7;
        end
    end

    // Stage 4: weekday as the remainder of the sum modulo 7.
    logic [11:0]   n4_q7;
    logic [SW-1:0] n4_rem;

    always_comb begin
        n4_q7  = r3_p7[utccet_pkg::RECIP_7_SHIFT +: 12];
        n4_rem = r3_sum - SW'(n4_q7) * SW'(3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_c    <= r3_c;
            r4_leap <= r3_leap;
            r4_wd   <= n4_rem[utccet_pkg::WDAY_W-1:0];
        end
    end

    // Stage 5: summer time rule, offset and date rollover.
    logic signed [6:0] n5_back;
    logic              n5_summer;
    logic [HW:0]       n5_hsum;
    logic [DW:0]       n5_day;
    logic [DW-1:0]     n5_dim;
    logic [MW:0]       n5_month;
    logic [YW-1:0]     n5_year;
    logic [HW-1:0]     n5_hour;
    utccet_pkg::t_local_time n5_out;

    always_comb begin
        n5_back = $signed({2'b00, r4_c.day}) - $signed({4'b0000, r4_wd});
        n5_summer = 1'b0;
        if (r4_c.month > utccet_pkg::MONTH_MAR && r4_c.month < utccet_pkg::MONTH_OCT) begin
            n5_summer = 1'b1;
        end else if (r4_c.month == utccet_pkg::MONTH_MAR) begin
            n5_summer = (n5_back >= utccet_pkg::LAST_WEEK)
                        && ((r4_wd != '0) || (r4_c.hour != '0));
        end else if (r4_c.month == utccet_pkg::MONTH_OCT) begin
            n5_summer = (n5_back < utccet_pkg::LAST_WEEK)
                        || ((r4_wd == '0) && (r4_c.hour == '0));
        end

        n5_hsum  = {1'b0, r4_c.hour} + (HW+1)'(1) + (HW+1)'(n5_summer);
        n5_hour  = n5_hsum[HW-1:0];
        n5_day   = {1'b0, r4_c.day};
        n5_month = {1'b0, r4_c.month};
        n5_year  = r4_c.year;
        n5_dim   = utccet_pkg::month_days(r4_c.month);
        if (r4_c.month == utccet_pkg::MONTH_FEB && r4_leap) begin
            n5_dim = utccet_pkg::LEAP_FEB;
        end

        // Carry past midnight into day, month and year.
        if (n5_hsum >= utccet_pkg::HOURS_DAY) begin
            n5_hour = HW'(n5_hsum - utccet_pkg::HOURS_DAY);
            n5_day  = {1'b0, r4_c.day} + (DW+1)'(1);
            if (n5_day > {1'b0, n5_dim}) begin
                n5_day   = (DW+1)'(1);
                n5_month = {1'b0, r4_c.month} + (MW+1)'(1);
                if (n5_month > {1'b0, utccet_pkg::MONTH_DEC}) begin
                    n5_month = (MW+1)'(1);
                    n5_year  = r4_c.year + YW'(1);
                end
            end
        end

        if (r4_c.synced) begin
            n5_out.synced       = 1'b1;
            n5_out.local_year   = n5_year;
            n5_out.local_month  = n5_month[MW-1:0];
            n5_out.local_day    = n5_day[DW-1:0];
            n5_out.local_hour   = n5_hour;
            n5_out.local_minute = r4_c.minute;
            n5_out.local_second = r4_c.second;
            n5_out.summer_time  = n5_summer;
            n5_out.utc_weekday  = r4_wd;
        end else begin
            n5_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_out <= n5_out;
        end
    end

    assign o_out.valid = r5_vld;
    assign o_out.data  = r5_out;

endmodule
